// ===== design/morton_neighbor_generator_assert.svh =====
// Assertion macros shared by the mng_seq and mng_encode modules.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MORTON_NEIGHBOR_GENERATOR_ASSERT_SVH
`define MORTON_NEIGHBOR_GENERATOR_ASSERT_SVH

// antecedent holds in the same cycle as the consequent
`define MNG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mng assertion failed");

// consequent holds in the cycle after the antecedent
`define MNG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mng assertion failed");

`endif

// ===== design/mng_pkg.sv =====
// Package for the Morton neighbor generator: widths, beat types,
// the neighbor offset table and the level clamp. No dependencies.
package mng_pkg;

    localparam int MAX_LEVEL     = 10;
    localparam int NUM_NEIGHBORS = 26;
    localparam int CODE_W        = 3 * MAX_LEVEL;
    localparam int CFG_W         = 4;
    localparam int IDX_W         = 5;
    localparam int LV_W          = $clog2(MAX_LEVEL + 1);
    localparam int CW            = MAX_LEVEL + 1;

    localparam logic [IDX_W-1:0] LAST_INDEX  = IDX_W'(NUM_NEIGHBORS - 1);
    localparam logic [CFG_W-1:0] LEVEL_RESET = CFG_W'(10);

    typedef logic [MAX_LEVEL-1:0] coord_t;
    typedef logic [CW-1:0]        wcoord_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [IDX_W-1:0]     index_t;
    typedef logic [LV_W-1:0]      lvl_t;
    typedef logic [CFG_W-1:0]     cfg_t;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
    } offs_t;

    typedef struct packed {
        index_t index;
        coord_t bx;
        coord_t by;
        coord_t bz;
    } seq_beat_t;

    typedef struct packed {
        index_t index;
        coord_t cx;
        coord_t cy;
        coord_t cz;
        logic   in_grid;
    } nb_beat_t;

    function automatic offs_t nb_offset(input index_t k);
        offs_t o;
        case (k)
            5'd0:    o = '{ 2'sd1,  2'sd0,  2'sd0};
            5'd1:    o = '{-2'sd1,  2'sd0,  2'sd0};
            5'd2:    o = '{ 2'sd0,  2'sd1,  2'sd0};
            5'd3:    o = '{ 2'sd0, -2'sd1,  2'sd0};
            5'd4:    o = '{ 2'sd0,  2'sd0,  2'sd1};
            5'd5:    o = '{ 2'sd0,  2'sd0, -2'sd1};
            5'd6:    o = '{ 2'sd1,  2'sd1,  2'sd1};
            5'd7:    o = '{-2'sd1, -2'sd1,  2'sd1};
            5'd8:    o = '{ 2'sd1, -2'sd1,  2'sd1};
            5'd9:    o = '{-2'sd1,  2'sd1,  2'sd1};
            5'd10:   o = '{ 2'sd1,  2'sd0,  2'sd1};
            5'd11:   o = '{-2'sd1,  2'sd0,  2'sd1};
            5'd12:   o = '{ 2'sd0,  2'sd1,  2'sd1};
            5'd13:   o = '{ 2'sd0, -2'sd1,  2'sd1};
            5'd14:   o = '{ 2'sd1,  2'sd1,  2'sd0};
            5'd15:   o = '{ 2'sd1, -2'sd1,  2'sd0};
            5'd16:   o = '{-2'sd1,  2'sd1,  2'sd0};
            5'd17:   o = '{-2'sd1, -2'sd1,  2'sd0};
            5'd18:   o = '{ 2'sd1,  2'sd1, -2'sd1};
            5'd19:   o = '{ 2'sd1, -2'sd1, -2'sd1};
            5'd20:   o = '{ 2'sd0,  2'sd1, -2'sd1};
            5'd21:   o = '{ 2'sd0, -2'sd1, -2'sd1};
            5'd22:   o = '{-2'sd1,  2'sd1, -2'sd1};
            5'd23:   o = '{-2'sd1, -2'sd1, -2'sd1};
            5'd24:   o = '{ 2'sd1,  2'sd0, -2'sd1};
            5'd25:   o = '{-2'sd1,  2'sd0, -2'sd1};
            default: o = '{ 2'sd0,  2'sd0,  2'sd0};
        endcase
        return o;
    endfunction

    function automatic lvl_t eff_level(input cfg_t lv);
        lvl_t r;
        if (lv == '0)
            r = LV_W'(1);
        else if (int'(lv) > MAX_LEVEL)
            r = LV_W'(MAX_LEVEL);
        else
            r = LV_W'(lv);
        return r;
    endfunction

endpackage

// ===== design/mng_seq.sv =====
// Input stage: decodes the Morton code and steps through the 26 offsets.
// Depends on mng_pkg and the assertion macro header.
`include "morton_neighbor_generator_assert.svh"
module mng_seq
    import mng_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lvl_t      lv,
    input  logic      in_valid,
    output logic      in_stall,
    input  code_t     morton_code,
    output logic      seq_valid,
    output seq_beat_t seq_beat,
    input  logic      seq_ready
);

    logic   busy_reg, busy_next;
    index_t k_reg, k_next;
    coord_t bx_reg, by_reg, bz_reg;
    coord_t dx, dy, dz;
    logic   issue, done, take;

    always_comb
    begin
        for (int i = 0; i < MAX_LEVEL; i++)
        begin
            dx[i] = morton_code[3 * i + 2] & (i < int'(lv));
            dy[i] = morton_code[3 * i + 1] & (i < int'(lv));
            dz[i] = morton_code[3 * i]     & (i < int'(lv));
        end
    end

    assign issue    = busy_reg && seq_ready;
    assign done     = issue && (k_reg == LAST_INDEX);
    assign in_stall = busy_reg && !done;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (take)
        begin
            busy_next = 1'b1;
            k_next    = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (issue)
        begin
            k_next = k_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bx_reg <= dx;
            by_reg <= dy;
            bz_reg <= dz;
        end
    end

    assign seq_valid = busy_reg;
    assign seq_beat  = '{index: k_reg, bx: bx_reg, by: by_reg, bz: bz_reg};

    `MNG_ASSERT_IMP(a_k_range, busy_reg, k_reg <= LAST_INDEX)
    `MNG_ASSERT_NEXT(a_k_step, issue && !done, busy_reg && k_reg == $past(k_reg) + IDX_W'(1))
    `MNG_ASSERT_IMP(a_hold_input, busy_reg && !done, in_stall)

endmodule

// ===== design/mng_offset.sv =====
// Offset stage: adds the neighbor offset per axis and checks the grid bounds.
// Depends on mng_pkg.
module mng_offset
    import mng_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lvl_t      lv,
    input  logic      seq_valid,
    input  seq_beat_t seq_beat,
    output logic      seq_ready,
    output logic      nb_valid,
    output nb_beat_t  nb_beat,
    input  logic      nb_ready
);

    logic     valid_reg;
    nb_beat_t beat_reg, beat_next;
    offs_t    off;
    wcoord_t  cx, cy, cz, limit;

    assign off   = nb_offset(seq_beat.index);
    assign limit = CW'(1) << lv;
    assign cx    = {1'b0, seq_beat.bx} + {{(CW - 2){off.dx[1]}}, off.dx};
    assign cy    = {1'b0, seq_beat.by} + {{(CW - 2){off.dy[1]}}, off.dy};
    assign cz    = {1'b0, seq_beat.bz} + {{(CW - 2){off.dz[1]}}, off.dz};

    always_comb
    begin
        beat_next.index   = seq_beat.index;
        beat_next.cx      = cx[MAX_LEVEL-1:0];
        beat_next.cy      = cy[MAX_LEVEL-1:0];
        beat_next.cz      = cz[MAX_LEVEL-1:0];
        beat_next.in_grid = (cx < limit) && (cy < limit) && (cz < limit);
    end

    assign seq_ready = !valid_reg || nb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (seq_ready)
            valid_reg <= seq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (seq_ready && seq_valid)
            beat_reg <= beat_next;
    end

    assign nb_valid = valid_reg;
    assign nb_beat  = beat_reg;

endmodule

// ===== design/mng_encode.sv =====
// Output stage: re-interleaves the neighbor coordinates into a Morton code
// and holds the result beat. Depends on mng_pkg and the assertion macros.
`include "morton_neighbor_generator_assert.svh"
module mng_encode
    import mng_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     nb_valid,
    input  nb_beat_t nb_beat,
    output logic     nb_ready,
    output logic     out_valid,
    input  logic     out_stall,
    output index_t   neighbor_index,
    output code_t    neighbor_code,
    output logic     inside_res,
    output logic     last
);

    logic   valid_reg;
    index_t index_reg;
    code_t  code_reg, code_next;
    logic   inside_reg, last_reg;

    always_comb
    begin
        code_next = '0;
        for (int i = 0; i < MAX_LEVEL; i++)
        begin
            code_next[3 * i + 2] = nb_beat.cx[i] & nb_beat.in_grid;
            code_next[3 * i + 1] = nb_beat.cy[i] & nb_beat.in_grid;
            code_next[3 * i]     = nb_beat.cz[i] & nb_beat.in_grid;
        end
    end

    assign nb_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (nb_ready)
            valid_reg <= nb_valid;
    end

    always_ff @(posedge clk)
    begin
        if (nb_ready && nb_valid)
        begin
            index_reg  <= nb_beat.index;
            code_reg   <= code_next;
            inside_reg <= nb_beat.in_grid;
            last_reg   <= (nb_beat.index == LAST_INDEX);
        end
    end

    assign out_valid      = valid_reg;
    assign neighbor_index = index_reg;
    assign neighbor_code  = code_reg;
    assign inside_res     = inside_reg;
    assign last           = last_reg;

    `MNG_ASSERT_IMP(a_outside_zero, valid_reg && !inside_reg, code_reg == '0)
    `MNG_ASSERT_IMP(a_last_index, valid_reg && last_reg, index_reg == LAST_INDEX)
    `MNG_ASSERT_IMP(a_index_range, valid_reg, index_reg <= LAST_INDEX)

endmodule

// ===== design/morton_neighbor_generator.sv =====
// Top level of the 26-neighbor Morton code generator.
// Depends on mng_pkg, mng_seq, mng_offset and mng_encode.
//
// Each accepted input beat yields 26 output beats, one per neighbor offset in
// index order, the last flagged by last; a neighbor off the grid comes out
// with inside_res low and a zero code. The offset counter in the input stage
// issues one neighbor per cycle while the offset stage is ready, and the next
// input beat is taken in the cycle its predecessor issues its final neighbor.
// Each result passes the input stage registers, the offset stage register and
// the output register. The level register (reset 10) clamps 0 to 1 and values
// above 10 to 10; write it only while the block is idle.
module morton_neighbor_generator
    import mng_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_wr_en,
    input  cfg_t   cfg_wr_data,
    input  logic   in_valid,
    output logic   in_stall,
    input  code_t  morton_code,
    output logic   out_valid,
    input  logic   out_stall,
    output index_t neighbor_index,
    output code_t  neighbor_code,
    output logic   inside_res,
    output logic   last
);

    cfg_t      level_reg;
    lvl_t      lv;
    logic      seq_valid, seq_ready, nb_valid, nb_ready;
    seq_beat_t seq_beat;
    nb_beat_t  nb_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= LEVEL_RESET;
        else if (cfg_wr_en)
            level_reg <= cfg_wr_data;
    end

    assign lv = eff_level(level_reg);

    mng_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .lv          (lv),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .morton_code (morton_code),
        .seq_valid   (seq_valid),
        .seq_beat    (seq_beat),
        .seq_ready   (seq_ready)
    );

    mng_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .lv        (lv),
        .seq_valid (seq_valid),
        .seq_beat  (seq_beat),
        .seq_ready (seq_ready),
        .nb_valid  (nb_valid),
        .nb_beat   (nb_beat),
        .nb_ready  (nb_ready)
    );

    mng_encode u_encode (
        .clk            (clk),
        .rst_n          (rst_n),
        .nb_valid       (nb_valid),
        .nb_beat        (nb_beat),
        .nb_ready       (nb_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .neighbor_index (neighbor_index),
        .neighbor_code  (neighbor_code),
        .inside_res     (inside_res),
        .last           (last)
    );

endmodule

// ===== sim/mng_checker.sv =====
`timescale 1ns / 100ps
// Checker for the Morton neighbor generator: tracks the level register, predicts
// the 26 neighbor beats of each accepted code and compares them in order.
// Depends on mng_pkg for the port types and the register reset value.
module mng_checker
    import mng_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_wr_en,
    input  cfg_t   cfg_wr_data,
    input  logic   in_valid,
    input  logic   in_stall,
    input  code_t  morton_code,
    input  logic   out_valid,
    input  logic   out_stall,
    input  index_t neighbor_index,
    input  code_t  neighbor_code,
    input  logic   inside_res,
    input  logic   last,
    output int     fail_count,
    output int     outstanding,
    output int     checked
);

    typedef struct {
        index_t index;
        code_t  code;
        logic   in_grid;
        logic   last;
    } neighbor_t;

    localparam int DX [0:25] = '{ 1, -1,  0,  0,  0,  0,  1, -1,  1, -1,  1, -1,  0,
                                  0,  1,  1, -1, -1,  1,  1,  0,  0, -1, -1,  1, -1};
    localparam int DY [0:25] = '{ 0,  0,  1, -1,  0,  0,  1, -1, -1,  1,  0,  0,  1,
                                 -1,  1, -1,  1, -1,  1, -1,  1, -1,  1, -1,  0,  0};
    localparam int DZ [0:25] = '{ 0,  0,  0,  0,  1, -1,  1,  1,  1,  1,  1,  1,  1,
                                  1,  0,  0,  0,  0, -1, -1, -1, -1, -1, -1, -1, -1};

    neighbor_t neighbor_q[$];
    neighbor_t got;
    cfg_t      level_reg;

    task automatic predict_neighbors(input code_t mc);
        int        lv;
        int        lim;
        int        bx;
        int        by;
        int        bz;
        int        cx;
        int        cy;
        int        cz;
        neighbor_t nb;
        if (level_reg == '0)
            lv = 1;
        else if (int'(level_reg) > MAX_LEVEL)
            lv = MAX_LEVEL;
        else
            lv = int'(level_reg);
        lim = 1 << lv;
        bx = 0;
        by = 0;
        bz = 0;
        for (int i = 0; i < lv; i++)
        begin
            bx |= int'(mc[3 * i + 2]) << i;
            by |= int'(mc[3 * i + 1]) << i;
            bz |= int'(mc[3 * i]) << i;
        end
        for (int k = 0; k < NUM_NEIGHBORS; k++)
        begin
            cx = bx + DX[k];
            cy = by + DY[k];
            cz = bz + DZ[k];
            nb.index   = index_t'(k);
            nb.in_grid = (cx >= 0 && cx < lim && cy >= 0 && cy < lim && cz >= 0 && cz < lim);
            nb.last    = (k == NUM_NEIGHBORS - 1);
            nb.code    = '0;
            if (nb.in_grid)
            begin
                for (int i = 0; i < lv; i++)
                begin
                    nb.code[3 * i + 2] = cx[i];
                    nb.code[3 * i + 1] = cy[i];
                    nb.code[3 * i]     = cz[i];
                end
            end
            neighbor_q.insert(neighbor_q.size(), nb);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg = LEVEL_RESET;
            neighbor_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
                level_reg = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (neighbor_q.size() == 0)
                begin
                    $error("neighbor beat with nothing expected: index %0d code %h",
                           neighbor_index, neighbor_code);
                    fail_count++;
                end
                else
                begin
                    got = neighbor_q.pop_front();
                    if (neighbor_index !== got.index)
                    begin
                        $error("neighbor_index: expected %0d, actual %0d",
                               got.index, neighbor_index);
                        fail_count++;
                    end
                    if (neighbor_code !== got.code)
                    begin
                        $error("neighbor_code: expected %h, actual %h",
                               got.code, neighbor_code);
                        fail_count++;
                    end
                    if (inside_res !== got.in_grid)
                    begin
                        $error("inside_res: expected %0b, actual %0b", got.in_grid, inside_res);
                        fail_count++;
                    end
                    if (last !== got.last)
                    begin
                        $error("last: expected %0b, actual %0b", got.last, last);
                        fail_count++;
                    end
                    checked++;
                end
            end
            if (in_valid && !in_stall)
                predict_neighbors(morton_code);
            outstanding = neighbor_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Top of the Morton neighbor generator testbench: clock, reset, stimulus and verdict.
// Depends on mng_pkg, morton_neighbor_generator and the mng_checker module.
module tb;
    import mng_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 41;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   cfg_wr_en   = 1'b0;
    cfg_t   cfg_wr_data = '0;
    logic   in_valid    = 1'b0;
    code_t  morton_code = '0;
    logic   out_stall   = 1'b0;
    logic   in_stall;
    logic   out_valid;
    index_t neighbor_index;
    code_t  neighbor_code;
    logic   inside_res;
    logic   last;

    int fail_count;
    int outstanding;
    int checked;
    int cycles;
    int items_sent;
    int cur_eff = MAX_LEVEL;
    bit snd_idle;
    bit rcv_idle;
    bit long_hold_req;

    morton_neighbor_generator uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .morton_code    (morton_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .neighbor_index (neighbor_index),
        .neighbor_code  (neighbor_code),
        .inside_res     (inside_res),
        .last           (last)
    );

    mng_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .morton_code    (morton_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .neighbor_index (neighbor_index),
        .neighbor_code  (neighbor_code),
        .inside_res     (inside_res),
        .last           (last),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .checked        (checked)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic code_t pack_coords(input int x, input int y, input int z, input int lv);
        code_t r;
        r = '0;
        for (int i = 0; i < lv; i++)
        begin
            r[3 * i + 2] = x[i];
            r[3 * i + 1] = y[i];
            r[3 * i]     = z[i];
        end
        return r;
    endfunction

    function automatic int pick_coord(input int lv);
        int c;
        case ($urandom_range(0, 5))
            0:       c = 0;
            1:       c = (1 << lv) - 1;
            2:       c = 1;
            3:       c = (1 << lv) - 2;
            default: c = $urandom_range(0, (1 << lv) - 1);
        endcase
        return (c < 0) ? 0 : c;
    endfunction

    task automatic send_code(input code_t c);
        int gap;
        gap = snd_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        morton_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_level(input cfg_t v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (v == '0)
            cur_eff = 1;
        else if (int'(v) > MAX_LEVEL)
            cur_eff = MAX_LEVEL;
        else
            cur_eff = int'(v);
    endtask

    // receiver: per-beat stall, plus one long hold on request
    initial
    begin
        int w;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            w = rcv_idle ? $urandom_range(0, 19) : 0;
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        code_t mask;
        code_t c;
        cfg_t  lv;
        snd_idle = 1'b1;
        rcv_idle = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners, faces and interior at the reset level
        send_code('0);
        send_code('1);
        send_code(pack_coords(1023, 0, 0, 10));
        send_code(pack_coords(0, 1023, 0, 10));
        send_code(pack_coords(0, 0, 1023, 10));
        send_code(pack_coords(1023, 1023, 0, 10));
        send_code(pack_coords(512, 511, 300, 10));

        set_level(4'd1);
        send_code('0);
        send_code(code_t'(7));
        send_code(30'h3FFFFFF8 | pack_coords(1, 0, 1, 1));
        send_code(30'h2AAAAAA8);

        set_level(4'd0);
        send_code('1);
        send_code(code_t'(2));

        set_level(4'd15);
        send_code('1);
        send_code(pack_coords(512, 511, 0, 10));

        set_level(4'd11);
        send_code(code_t'($urandom()));

        set_level(4'd5);
        send_code(pack_coords(31, 0, 15, 5) | 30'h3FFF8000);
        send_code(pack_coords(16, 15, 1, 5));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       lv = 4'd1;
                1:       lv = 4'd10;
                2:       lv = 4'd0;
                3:       lv = 4'd15;
                default: lv = cfg_t'($urandom_range(0, 15));
            endcase
            set_level(lv);
            snd_idle = (phase % 3 != 0);
            rcv_idle = (phase % 4 != 1);
            if (phase == 5)
            begin
                snd_idle      = 1'b0;
                long_hold_req = 1'b1;
            end
            mask = code_t'((64'd1 << (3 * cur_eff)) - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 7 && n == PHASE_ITEMS / 2)
                    drain();
                if ($urandom_range(0, 3) == 0)
                    c = code_t'($urandom());
                else
                    c = pack_coords(pick_coord(cur_eff), pick_coord(cur_eff),
                                    pick_coord(cur_eff), cur_eff)
                        | (code_t'($urandom()) & ~mask);
                send_code(c);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d input codes and %0d neighbor beats over levels 0 to 15,",
                 items_sent, checked);
        $display("with random gaps on both sides, a long output hold and idle drains.");
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
